// File: src/bis_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_pkg
// Shared types and constants of the bilinear image scaler.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_SRC_WIDTH  = 512;
  localparam int MAX_SRC_HEIGHT = 512;
  localparam int FRAC_BITS      = 16;
  localparam int STORE_DEPTH    = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;
  localparam int ADDR_W         = $clog2(STORE_DEPTH);
  localparam int DIM_W          = 10;
  localparam int STEP_W         = 25;
  localparam int COORD_W        = 12;
  localparam int POS_W          = COORD_W + STEP_W;
  localparam int PIX_W          = 24;
  localparam int WGT_W          = 2 * FRAC_BITS + 1;
  localparam int NUM_W          = 2 * FRAC_BITS + 8;
  localparam int CFG_IDX_W      = 3;

  localparam logic CMD_LOAD    = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  localparam logic FMT_565 = 1'b0;
  localparam logic FMT_888 = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_FMT    = 3'd4;

  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [STEP_W-1:0] x_step;
    logic [STEP_W-1:0] y_step;
    logic              pixel_format;
  } bis_cfg_t;

  typedef struct packed {
    logic               compute;
    logic [COORD_W-1:0] column;
    logic [COORD_W-1:0] line;
    logic [ADDR_W-1:0]  waddr;
    logic [PIX_W-1:0]   rgb;
  } bis_item_t;

endpackage

// File: src/bilinear_image_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bilinear_image_scaler
// Frame store plus bilinear resampler for RGB images.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): cmd 0 loads one source pixel into
// the frame store, cmd 1 asks for one destination pixel. Loads outside the
// configured source size are dropped. Output channel (out_valid_o /
// out_stall_i) returns one transfer per compute, in order, none per load.
// Throughput is one item per cycle while the receiver does not stall, set by
// the two dual-read store copies that supply the four neighbors of a pixel
// together. A four-entry queue sits behind the input; when the receiver
// stalls the back pipeline holds, the queue fills and in_stall_o rises.
// The user writes configuration through cfg_we_i / cfg_idx_i / cfg_data_i
// only while idle; the block does not enforce it. Reset clears control
// state and loads the register defaults (512x512, unit steps, 24-bit
// format); store contents stay undefined until written.
// ----------------------------------------------------------------------------
module bilinear_image_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bis_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bis_pkg::STEP_W-1:0]    cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          cmd_i,
  input  logic [bis_pkg::COORD_W-1:0]   column_i,
  input  logic [bis_pkg::COORD_W-1:0]   line_i,
  input  logic [7:0]                    red_in_i,
  input  logic [7:0]                    green_in_i,
  input  logic [7:0]                    blue_in_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    red_out_o,
  output logic [7:0]                    green_out_o,
  output logic [7:0]                    blue_out_o,
  output logic [15:0]                   packed_565_o,
  output logic                          overflow_o
);
  import bis_pkg::*;

  logic [DIM_W-1:0]  src_width_q, src_height_q;
  logic [STEP_W-1:0] x_step_q, y_step_q;
  logic              pix_fmt_q;
  bis_cfg_t          cfg;
  logic              push, full, q_valid, q_pop;
  bis_item_t         f_item, q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q  <= DIM_W'(MAX_SRC_WIDTH);
      src_height_q <= DIM_W'(MAX_SRC_HEIGHT);
      x_step_q     <= STEP_W'(1) << FRAC_BITS;
      y_step_q     <= STEP_W'(1) << FRAC_BITS;
      pix_fmt_q    <= FMT_888;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SRC_WIDTH:  src_width_q  <= cfg_data_i[DIM_W-1:0];
        REG_SRC_HEIGHT: src_height_q <= cfg_data_i[DIM_W-1:0];
        REG_X_STEP:     x_step_q     <= cfg_data_i;
        REG_Y_STEP:     y_step_q     <= cfg_data_i;
        REG_PIX_FMT:    pix_fmt_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width        = (src_width_q > DIM_W'(MAX_SRC_WIDTH)) ?
                       DIM_W'(MAX_SRC_WIDTH) : src_width_q;
    cfg.height       = (src_height_q > DIM_W'(MAX_SRC_HEIGHT)) ?
                       DIM_W'(MAX_SRC_HEIGHT) : src_height_q;
    cfg.x_step       = x_step_q;
    cfg.y_step       = y_step_q;
    cfg.pixel_format = pix_fmt_q;
  end

  assign in_stall_o = full;

  bis_front u_front (
    .cfg_i      (cfg),
    .in_valid_i (in_valid_i),
    .cmd_i      (cmd_i),
    .column_i   (column_i),
    .line_i     (line_i),
    .red_in_i   (red_in_i),
    .green_in_i (green_in_i),
    .blue_in_i  (blue_in_i),
    .push_o     (push),
    .item_o     (f_item)
  );

  bis_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (f_item),
    .full_o  (full),
    .valid_o (q_valid),
    .item_o  (q_item),
    .pop_i   (q_pop)
  );

  bis_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg),
    .q_valid_i    (q_valid),
    .q_item_i     (q_item),
    .q_pop_o      (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_out_o    (red_out_o),
    .green_out_o  (green_out_o),
    .blue_out_o   (blue_out_o),
    .packed_565_o (packed_565_o),
    .overflow_o   (overflow_o)
  );

endmodule

// File: src/bis_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_front
// Classifies input transfers: drops out-of-bounds loads, forms store addresses.
// ----------------------------------------------------------------------------
module bis_front (
  input  bis_pkg::bis_cfg_t           cfg_i,
  input  logic                        in_valid_i,
  input  logic                        cmd_i,
  input  logic [bis_pkg::COORD_W-1:0] column_i,
  input  logic [bis_pkg::COORD_W-1:0] line_i,
  input  logic [7:0]                  red_in_i,
  input  logic [7:0]                  green_in_i,
  input  logic [7:0]                  blue_in_i,
  output logic                        push_o,
  output bis_pkg::bis_item_t          item_o
);
  import bis_pkg::*;

  logic              in_bounds;
  logic [ADDR_W:0]   laddr;

  assign in_bounds = (column_i < COORD_W'(cfg_i.width)) && (line_i < COORD_W'(cfg_i.height));
  assign laddr     = (ADDR_W+1)'(line_i[8:0] * cfg_i.width) + (ADDR_W+1)'(column_i[8:0]);

  assign push_o = in_valid_i && ((cmd_i == CMD_COMPUTE) || in_bounds);

  always_comb begin
    item_o.compute = (cmd_i == CMD_COMPUTE);
    item_o.column  = column_i;
    item_o.line    = line_i;
    item_o.waddr   = laddr[ADDR_W-1:0];
    item_o.rgb     = {red_in_i, green_in_i, blue_in_i};
  end

endmodule

// File: src/bis_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_queue
// Four-entry queue between the front and the back.
// ----------------------------------------------------------------------------
module bis_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  bis_pkg::bis_item_t item_i,
  output logic               full_o,
  output logic               valid_o,
  output bis_pkg::bis_item_t item_o,
  input  logic               pop_i
);
  import bis_pkg::*;

  bis_item_t  buf_q [4];
  logic [1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [2:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 3'd4);
  assign valid_o = (cnt_q != 3'd0);
  assign item_o  = buf_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = do_push ? wptr_q + 2'd1 : wptr_q;
    rptr_d = do_pop ? rptr_q + 2'd1 : rptr_q;
    cnt_d  = cnt_q + 3'(do_push) - 3'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wptr_q] <= item_i;
    end
  end

endmodule

// File: src/bis_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bis_back
// Mapping, frame store and bilinear blend pipeline with output register.
// ----------------------------------------------------------------------------
module bis_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  bis_pkg::bis_cfg_t  cfg_i,
  input  logic               q_valid_i,
  input  bis_pkg::bis_item_t q_item_i,
  output logic               q_pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         red_out_o,
  output logic [7:0]         green_out_o,
  output logic [7:0]         blue_out_o,
  output logic [15:0]        packed_565_o,
  output logic               overflow_o
);
  import bis_pkg::*;

  localparam logic [FRAC_BITS:0] UNIT = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic en;

  // stage 1
  logic              v1_q, c1_q;
  logic [ADDR_W-1:0] wa1_q;
  logic [PIX_W-1:0]  rgb1_q;
  logic [POS_W-1:0]  sx_q, sy_q;
  // stage 2
  logic                 v2_q, c2_q;
  logic [ADDR_W-1:0]    wa2_q, a_q;
  logic [PIX_W-1:0]     rgb2_q;
  logic [FRAC_BITS-1:0] fx_q, fy_q;
  logic [ADDR_W-1:0]    ybase;
  // stage 3
  logic                 v3_q, c3_q;
  logic [PIX_W-1:0]     px_q [4];
  logic [WGT_W-1:0]     wgt_q [4];
  logic [FRAC_BITS:0]   gx, gy;
  logic [ADDR_W-1:0]    a1, aw, aw1;
  logic [PIX_W-1:0]     store0_q [STORE_DEPTH];
  logic [PIX_W-1:0]     store1_q [STORE_DEPTH];
  // stage 4
  logic                 v4_q, c4_q;
  logic [NUM_W-1:0]     prod_q [3][4];
  logic [NUM_W-1:0]     num [3];
  logic [7:0]           chan [3];
  logic                 ovf [3];
  // output
  logic                 out_valid_q;
  logic [7:0]           r_q, g_q, b_q;
  logic [15:0]          pk_q;
  logic                 ovf_q;

  assign en      = !(out_valid_q && out_stall_i);
  assign q_pop_o = en && q_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= q_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      out_valid_q <= v4_q && c4_q;
    end
  end

  // stage 1: source position
  always_ff @(posedge clk_i) begin
    if (en) begin
      c1_q   <= q_item_i.compute;
      wa1_q  <= q_item_i.waddr;
      rgb1_q <= q_item_i.rgb;
      sx_q   <= POS_W'(q_item_i.column) * POS_W'(cfg_i.x_step);
      sy_q   <= POS_W'(q_item_i.line) * POS_W'(cfg_i.y_step);
    end
  end

  // stage 2: base address and fractions
  assign ybase = ADDR_W'(sy_q[FRAC_BITS +: ADDR_W] * cfg_i.width);

  always_ff @(posedge clk_i) begin
    if (en) begin
      c2_q   <= c1_q;
      wa2_q  <= wa1_q;
      rgb2_q <= rgb1_q;
      a_q    <= ybase + sx_q[FRAC_BITS +: ADDR_W];
      fx_q   <= sx_q[FRAC_BITS-1:0];
      fy_q   <= sy_q[FRAC_BITS-1:0];
    end
  end

  // stage 3: store access and weights
  assign gx  = UNIT - (FRAC_BITS+1)'(fx_q);
  assign gy  = UNIT - (FRAC_BITS+1)'(fy_q);
  assign a1  = a_q + ADDR_W'(1);
  assign aw  = a_q + ADDR_W'(cfg_i.width);
  assign aw1 = aw + ADDR_W'(1);

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (v2_q && !c2_q) begin
        store0_q[wa2_q] <= rgb2_q;
        store1_q[wa2_q] <= rgb2_q;
      end
      px_q[0] <= store0_q[a_q];
      px_q[1] <= store0_q[a1];
      px_q[2] <= store1_q[aw];
      px_q[3] <= store1_q[aw1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c3_q     <= c2_q;
      wgt_q[0] <= WGT_W'(gx * gy);
      wgt_q[1] <= WGT_W'((FRAC_BITS+1)'(fx_q) * gy);
      wgt_q[2] <= WGT_W'(gx * (FRAC_BITS+1)'(fy_q));
      wgt_q[3] <= WGT_W'((FRAC_BITS+1)'(fx_q) * (FRAC_BITS+1)'(fy_q));
    end
  end

  // stage 4: per-tap products
  always_ff @(posedge clk_i) begin
    if (en) begin
      c4_q <= c3_q;
      for (int c = 0; c < 3; c++) begin
        for (int t = 0; t < 4; t++) begin
          prod_q[c][t] <= NUM_W'(px_q[t][16 - 8*c +: 8] * wgt_q[t]);
        end
      end
    end
  end

  // sum, range check, pack
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      num[c] = prod_q[c][0] + prod_q[c][1] + prod_q[c][2] + prod_q[c][3];
      if (c == 1) begin
        ovf[c] = num[c] > (NUM_W'(63) << (2 * FRAC_BITS));
      end else begin
        ovf[c] = num[c] > (NUM_W'(31) << (2 * FRAC_BITS));
      end
      ovf[c]  = ovf[c] && (cfg_i.pixel_format == FMT_565);
      chan[c] = ovf[c] ? 8'd15 : num[c][2*FRAC_BITS +: 8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r_q   <= chan[0];
      g_q   <= chan[1];
      b_q   <= chan[2];
      ovf_q <= ovf[0] || ovf[1] || ovf[2];
      pk_q  <= (cfg_i.pixel_format == FMT_565) ?
               {chan[2][4:0], chan[1][5:0], chan[0][4:0]} : 16'd0;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign red_out_o    = r_q;
  assign green_out_o  = g_q;
  assign blue_out_o   = b_q;
  assign packed_565_o = pk_q;
  assign overflow_o   = ovf_q;

endmodule
